/* hw/rtl/usvg_pkg.sv */
`default_nettype none

package usvg_pkg;

    localparam int SEG_W   = 9;
    localparam int RAD_W   = 16;
    localparam int CFG_W   = 2;
    localparam int Q_W     = 34;
    localparam int PH_W    = 32;
    localparam int CORD_W  = 33;
    localparam int Z_W     = 33;
    localparam int TRIG_W  = 18;
    localparam int PROD_W  = 36;
    localparam int RCT_W   = 35;
    localparam int RPROD_W = 53;
    localparam int COMP_W  = 32;
    localparam int TEX_W   = 17;

    localparam int DIV_STAGES      = 11;
    localparam int DIV_STEPS       = 3;
    localparam int CORDIC_STEPS    = 30;
    localparam int COR_STEPS       = 3;
    localparam int COR_ITER_STAGES = 10;

    localparam int ST_COR_IN  = DIV_STAGES + 1;
    localparam int ST_COR_OUT = DIV_STAGES + COR_ITER_STAGES + 2;
    localparam int ST_M1      = ST_COR_OUT + 1;
    localparam int ST_M2      = ST_COR_OUT + 2;
    localparam int ST_M3      = ST_COR_OUT + 3;
    localparam int ST_M4      = ST_COR_OUT + 4;
    localparam int ST_N       = ST_M4 + 1;
    localparam int TEX_N      = ST_M4 - ST_COR_IN;

    localparam logic [CFG_W-1:0] CFG_RADIUS  = 2'd0;
    localparam logic [CFG_W-1:0] CFG_LAT_SEG = 2'd1;
    localparam logic [CFG_W-1:0] CFG_LON_SEG = 2'd2;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd256;
    localparam logic [SEG_W-1:0] SEG_RESET    = 9'd16;

    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [Z_W-1:0] HALF_TURN    = 33'sd2147483648;
    localparam logic signed [Z_W-1:0] QUARTER_TURN = 33'sd1073741824;

    localparam logic signed [Z_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
        33'sd42667331, 33'sd21354465, 33'sd10679838, 33'sd5340245,
        33'sd2670163, 33'sd1335087, 33'sd667544, 33'sd333772,
        33'sd166886, 33'sd83443, 33'sd41722, 33'sd20861,
        33'sd10430, 33'sd5215, 33'sd2608, 33'sd1304,
        33'sd652, 33'sd326, 33'sd163, 33'sd81,
        33'sd41, 33'sd20, 33'sd10, 33'sd5,
        33'sd3, 33'sd1
    };

    typedef enum logic [2:0] {
        KIND_POS,
        KIND_NORMAL,
        KIND_TANGENT,
        KIND_BITANGENT,
        KIND_TEXCOORD
    } t_attr_kind;

    typedef struct packed {
        logic             qbit;
        logic [SEG_W-1:0] rem;
    } t_div_res;

    function automatic t_div_res div_step(input logic [SEG_W-1:0] rem,
                                          input logic [SEG_W-1:0] den);
        logic [SEG_W:0] sh;
        t_div_res       res;
        sh = {rem, 1'b0};
        if (sh >= {1'b0, den}) begin
            res.qbit = 1'b1;
            res.rem  = SEG_W'(sh - {1'b0, den});
        end else begin
            res.qbit = 1'b0;
            res.rem  = sh[SEG_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [TRIG_W-1:0] q30_to_q16(
        input logic signed [CORD_W-1:0] v);
        logic signed [CORD_W-1:0] r;
        r = (v + 33'sd8192) >>> 14;
        if (r > 33'sd65536) begin
            r = 33'sd65536;
        end else if (r < -33'sd65536) begin
            r = -33'sd65536;
        end
        return TRIG_W'(r);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/uv_sphere_vertex_generator_unit.sv */
`default_nettype none

// channel  direction  handshake                      payload
// s_axis   in         s_axis_tvalid / s_axis_tready  tdata: lat_index, lon_index
// m_axis   out        m_axis_tvalid / m_axis_tready  tdata: x, y, z; tuser: kind; tlast
// cfg      in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// 28 register stages: index clamp, 11 divider stages (3 quotient bits each, 4 in the first),
// 12 CORDIC stages (fold, 10 x 3 rotations, scale), 4 multiply stages.
// The output port sends one of a vertex's five words a cycle while m_axis_tready is high.
// Reset is synchronous and clears the stage valids, the word select and the configuration registers to defaults.
// The whole pipe holds while its last stage is full and its last word is not being taken.

module uv_sphere_vertex_generator_unit #(
    parameter int MAX_SEGMENTS = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [23:0]                   s_axis_tdata,  // lat_index, lon_index
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [95:0]                   m_axis_tdata,  // comp_x, comp_y, comp_z
    output logic      [2:0]                    m_axis_tuser,  // attribute_kind
    output logic                               m_axis_tlast,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [usvg_pkg::CFG_W-1:0]    i_cfg_index,
    input  wire logic [usvg_pkg::RAD_W-1:0]    i_cfg_data
);

    localparam int SW = usvg_pkg::SEG_W;
    localparam int TW = usvg_pkg::TRIG_W;
    localparam int PW = usvg_pkg::PROD_W;
    localparam int CW = usvg_pkg::COMP_W;
    localparam int XW = usvg_pkg::TEX_W;
    localparam int NS = usvg_pkg::ST_N;

    logic [usvg_pkg::RAD_W-1:0] r_radius;
    logic [SW-1:0]              r_lat_seg;
    logic [SW-1:0]              r_lon_seg;
    logic [SW-1:0]              w_lat_seg;
    logic [SW-1:0]              w_lon_seg;
    logic signed [usvg_pkg::RAD_W:0] w_rad_s;

    logic [NS-1:0]              r_v;
    logic                       w_adv;
    usvg_pkg::t_attr_kind       r_beat;
    usvg_pkg::t_attr_kind       n_beat;

    logic [SW-1:0]              w_in_lat;
    logic [SW-1:0]              w_in_lon;
    logic [SW-1:0]              r_lat;
    logic [SW-1:0]              r_lon;

    logic [usvg_pkg::Q_W-1:0]   w_q_lat;
    logic [usvg_pkg::Q_W-1:0]   w_q_lon;
    logic [usvg_pkg::Q_W-1:0]   w_th_t;
    logic [usvg_pkg::Q_W:0]     w_ph_t;
    logic [XW+1:0]              w_u_t;
    logic [XW+1:0]              w_v_t;
    logic [usvg_pkg::PH_W-1:0]  w_th_ph;
    logic [usvg_pkg::PH_W-1:0]  w_ph_ph;
    logic [XW-1:0]              r_u [usvg_pkg::TEX_N];
    logic [XW-1:0]              r_vt [usvg_pkg::TEX_N];

    logic signed [TW-1:0] w_st, w_ct, w_sp, w_cp;

    logic signed [PW-1:0]                 r1_p1, r1_p2;
    logic signed [usvg_pkg::RCT_W-1:0]    r1_rct;
    logic signed [TW-1:0]                 r1_ct, r1_sp, r1_cp;

    logic signed [usvg_pkg::RPROD_W-1:0]  r2_rp1, r2_rp2;
    logic signed [TW-1:0]                 r2_nx, r2_nz, r2_ct, r2_sp, r2_cp;
    logic signed [CW-1:0]                 r2_posy;

    logic signed [CW-1:0]                 r3_posx, r3_posy, r3_posz;
    logic signed [PW-1:0]                 r3_a, r3_b, r3_c, r3_d;
    logic signed [TW-1:0]                 r3_nx, r3_nz, r3_ct, r3_sp, r3_cp;

    logic signed [PW+1:0]                 w_b_ext, w_c_ext, w_by_sum;

    logic signed [CW-1:0]                 r4_posx, r4_posy, r4_posz;
    logic signed [TW-1:0]                 r4_nx, r4_ny, r4_nz, r4_tx, r4_tz;
    logic signed [CW-1:0]                 r4_bx, r4_by, r4_bz;
    logic [XW-1:0]                        r4_u, r4_v;

    logic [CW-1:0] w_ox, w_oy, w_oz;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= usvg_pkg::RADIUS_RESET;
            r_lat_seg <= usvg_pkg::SEG_RESET;
            r_lon_seg <= usvg_pkg::SEG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                usvg_pkg::CFG_RADIUS:  r_radius  <= i_cfg_data;
                usvg_pkg::CFG_LAT_SEG: r_lat_seg <= i_cfg_data[SW-1:0];
                usvg_pkg::CFG_LON_SEG: r_lon_seg <= i_cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_lat_seg == '0) begin
            w_lat_seg = SW'(1);
        end else if (32'(r_lat_seg) > MAX_SEGMENTS) begin
            w_lat_seg = SW'(MAX_SEGMENTS);
        end else begin
            w_lat_seg = r_lat_seg;
        end
        if (r_lon_seg == '0) begin
            w_lon_seg = SW'(1);
        end else if (32'(r_lon_seg) > MAX_SEGMENTS) begin
            w_lon_seg = SW'(MAX_SEGMENTS);
        end else begin
            w_lon_seg = r_lon_seg;
        end
    end

    assign w_rad_s = {1'b0, r_radius};

    // pipe control
    assign w_adv = !r_v[NS-1] || (m_axis_tready && r_beat == usvg_pkg::KIND_TEXCOORD);
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_beat <= usvg_pkg::KIND_POS;
        end else begin
            r_beat <= n_beat;
            if (w_adv) begin
                r_v <= {r_v[NS-2:0], s_axis_tvalid};
            end
        end
    end

    always_comb begin
        n_beat = r_beat;
        if (w_adv) begin
            n_beat = usvg_pkg::KIND_POS;
        end else if (m_axis_tready) begin
            unique case (r_beat)
                usvg_pkg::KIND_POS:       n_beat = usvg_pkg::KIND_NORMAL;
                usvg_pkg::KIND_NORMAL:    n_beat = usvg_pkg::KIND_TANGENT;
                usvg_pkg::KIND_TANGENT:   n_beat = usvg_pkg::KIND_BITANGENT;
                usvg_pkg::KIND_BITANGENT: n_beat = usvg_pkg::KIND_TEXCOORD;
                usvg_pkg::KIND_TEXCOORD:  n_beat = usvg_pkg::KIND_TEXCOORD;
                default:                  n_beat = usvg_pkg::KIND_POS;
            endcase
        end
    end

    // stage 0: index clamp
    assign w_in_lat = s_axis_tdata[8:0];
    assign w_in_lon = s_axis_tdata[17:9];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lat <= (w_in_lat > w_lat_seg) ? w_lat_seg : w_in_lat;
            r_lon <= (w_in_lon > w_lon_seg) ? w_lon_seg : w_in_lon;
        end
    end

    // quotients floor(idx * 2^33 / seg)
    usvg_div u_div_lat (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_lat),
        .i_den (w_lat_seg),
        .o_quo (w_q_lat)
    );

    usvg_div u_div_lon (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_lon),
        .i_den (w_lon_seg),
        .o_quo (w_q_lon)
    );

    assign w_th_t  = {1'b0, w_q_lat[usvg_pkg::Q_W-1:1]} + usvg_pkg::Q_W'(1);
    assign w_th_ph = w_th_t[usvg_pkg::PH_W:1];
    assign w_ph_t  = {1'b0, w_q_lon} + (usvg_pkg::Q_W + 1)'(1);
    assign w_ph_ph = w_ph_t[usvg_pkg::PH_W:1];
    assign w_u_t   = {1'b0, w_q_lon[usvg_pkg::Q_W-1:16]} + (XW + 2)'(1);
    assign w_v_t   = {1'b0, w_q_lat[usvg_pkg::Q_W-1:16]} + (XW + 2)'(1);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_u[0]  <= w_u_t[XW:1];
            r_vt[0] <= w_v_t[XW:1];
            for (int j = 1; j < usvg_pkg::TEX_N; j++) begin
                r_u[j]  <= r_u[j-1];
                r_vt[j] <= r_vt[j-1];
            end
        end
    end

    usvg_cordic u_cordic_th (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_phase (w_th_ph),
        .o_sin   (w_st),
        .o_cos   (w_ct)
    );

    usvg_cordic u_cordic_ph (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_phase (w_ph_ph),
        .o_sin   (w_sp),
        .o_cos   (w_cp)
    );

    // multiply stages
    assign w_b_ext  = r3_b;
    assign w_c_ext  = r3_c;
    assign w_by_sum = -w_b_ext - w_c_ext + 38'sd32768;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_p1  <= w_st * w_cp;
            r1_p2  <= w_st * w_sp;
            r1_rct <= w_rad_s * w_ct;
            r1_ct  <= w_ct;
            r1_sp  <= w_sp;
            r1_cp  <= w_cp;

            r2_rp1  <= w_rad_s * r1_p1;
            r2_rp2  <= w_rad_s * r1_p2;
            r2_nx   <= TW'((r1_p1 + 36'sd32768) >>> 16);
            r2_nz   <= TW'((r1_p2 + 36'sd32768) >>> 16);
            r2_posy <= CW'((r1_rct + 35'sd128) >>> 8);
            r2_ct   <= r1_ct;
            r2_sp   <= r1_sp;
            r2_cp   <= r1_cp;

            r3_posx <= CW'((r2_rp1 + 53'sd8388608) >>> 24);
            r3_posz <= CW'((r2_rp2 + 53'sd8388608) >>> 24);
            r3_posy <= r2_posy;
            r3_a    <= r2_ct * r2_cp;
            r3_b    <= r2_nz * r2_sp;
            r3_c    <= r2_nx * r2_cp;
            r3_d    <= r2_ct * r2_sp;
            r3_nx   <= r2_nx;
            r3_nz   <= r2_nz;
            r3_ct   <= r2_ct;
            r3_sp   <= r2_sp;
            r3_cp   <= r2_cp;

            r4_posx <= r3_posx;
            r4_posy <= r3_posy;
            r4_posz <= r3_posz;
            r4_nx   <= r3_nx;
            r4_ny   <= r3_ct;
            r4_nz   <= r3_nz;
            r4_tx   <= -r3_sp;
            r4_tz   <= r3_cp;
            r4_bx   <= CW'((r3_a + 36'sd32768) >>> 16);
            r4_by   <= CW'(w_by_sum >>> 16);
            r4_bz   <= CW'((r3_d + 36'sd32768) >>> 16);
            r4_u    <= r_u[usvg_pkg::TEX_N-1];
            r4_v    <= r_vt[usvg_pkg::TEX_N-1];
        end
    end

    // output word select
    always_comb begin
        unique case (r_beat)
            usvg_pkg::KIND_POS: begin
                w_ox = r4_posx;
                w_oy = r4_posy;
                w_oz = r4_posz;
            end
            usvg_pkg::KIND_NORMAL: begin
                w_ox = CW'(r4_nx);
                w_oy = CW'(r4_ny);
                w_oz = CW'(r4_nz);
            end
            usvg_pkg::KIND_TANGENT: begin
                w_ox = CW'(r4_tx);
                w_oy = '0;
                w_oz = CW'(r4_tz);
            end
            usvg_pkg::KIND_BITANGENT: begin
                w_ox = r4_bx;
                w_oy = r4_by;
                w_oz = r4_bz;
            end
            usvg_pkg::KIND_TEXCOORD: begin
                w_ox = {{(CW - XW){1'b0}}, r4_u};
                w_oy = {{(CW - XW){1'b0}}, r4_v};
                w_oz = '0;
            end
            default: begin
                w_ox = '0;
                w_oy = '0;
                w_oz = '0;
            end
        endcase
    end

    assign m_axis_tvalid = r_v[NS-1];
    assign m_axis_tdata  = {w_oz, w_oy, w_ox};
    assign m_axis_tuser  = r_beat;
    assign m_axis_tlast  = (r_beat == usvg_pkg::KIND_TEXCOORD);

    a_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_beat != usvg_pkg::KIND_TEXCOORD) |-> !s_axis_tready)
        else $error("input taken while vertex words remain");

    a_beat_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && r_beat == usvg_pkg::KIND_POS)
        |=> (m_axis_tvalid && r_beat == usvg_pkg::KIND_NORMAL))
        else $error("word sequence broken after position");

    a_tangent_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == usvg_pkg::KIND_TANGENT)
        |-> (m_axis_tdata[63:32] == '0))
        else $error("tangent y not zero");

    a_tex_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[95:64] == '0))
        else $error("texcoord z not zero");

endmodule

`default_nettype wire

/* hw/rtl/usvg_div.sv */
`default_nettype none

module usvg_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [usvg_pkg::SEG_W-1:0]  i_num,
    input  wire logic [usvg_pkg::SEG_W-1:0]  i_den,
    output logic      [usvg_pkg::Q_W-1:0]    o_quo
);

    localparam int NS = usvg_pkg::DIV_STAGES;

    logic [usvg_pkg::SEG_W-1:0] r_rem [NS];
    logic [usvg_pkg::Q_W-1:0]   r_quo [NS];
    logic [usvg_pkg::SEG_W-1:0] w_ri  [NS];
    logic [usvg_pkg::Q_W-1:0]   w_qi  [NS];
    logic [usvg_pkg::SEG_W-1:0] n_rem [NS];
    logic [usvg_pkg::Q_W-1:0]   n_quo [NS];

    for (genvar g = 0; g < NS; g++) begin : g_st
        if (g == 0) begin : g_head
            assign w_qi[g] = {{(usvg_pkg::Q_W-1){1'b0}}, (i_num >= i_den)};
            assign w_ri[g] = (i_num >= i_den) ? i_num - i_den : i_num;
        end else begin : g_body
            assign w_qi[g] = r_quo[g-1];
            assign w_ri[g] = r_rem[g-1];
        end

        always_comb begin
            logic [usvg_pkg::SEG_W-1:0] rem;
            logic [usvg_pkg::Q_W-1:0]   quo;
            usvg_pkg::t_div_res         st;
            rem = w_ri[g];
            quo = w_qi[g];
            for (int k = 0; k < usvg_pkg::DIV_STEPS; k++) begin
                st  = usvg_pkg::div_step(rem, i_den);
                rem = st.rem;
                quo = {quo[usvg_pkg::Q_W-2:0], st.qbit};
            end
            n_rem[g] = rem;
            n_quo[g] = quo;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem[g];
                r_quo[g] <= n_quo[g];
            end
        end
    end

    assign o_quo = r_quo[NS-1];

endmodule

`default_nettype wire

/* hw/rtl/usvg_cordic.sv */
`default_nettype none

module usvg_cordic (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire logic        [usvg_pkg::PH_W-1:0]   i_phase,
    output logic signed      [usvg_pkg::TRIG_W-1:0] o_sin,
    output logic signed      [usvg_pkg::TRIG_W-1:0] o_cos
);

    localparam int NS = usvg_pkg::COR_ITER_STAGES;
    localparam int CW = usvg_pkg::CORD_W;
    localparam int ZW = usvg_pkg::Z_W;

    logic signed [ZW-1:0] w_z_raw;
    logic signed [ZW-1:0] n_z0;
    logic                 n_neg0;
    logic signed [ZW-1:0] r_z0;
    logic                 r_neg0;

    logic signed [CW-1:0] r_x [NS];
    logic signed [CW-1:0] r_y [NS];
    logic signed [ZW-1:0] r_z [NS];
    logic                 r_neg [NS];
    logic signed [CW-1:0] w_xi [NS];
    logic signed [CW-1:0] w_yi [NS];
    logic signed [ZW-1:0] w_zi [NS];
    logic                 w_ni [NS];
    logic signed [CW-1:0] n_x [NS];
    logic signed [CW-1:0] n_y [NS];
    logic signed [ZW-1:0] n_z [NS];

    logic signed [CW-1:0] w_xf;
    logic signed [CW-1:0] w_yf;

    // fold into [-quarter, +quarter] turn
    assign w_z_raw = ZW'($signed(i_phase));

    always_comb begin
        n_z0   = w_z_raw;
        n_neg0 = 1'b0;
        if (w_z_raw > usvg_pkg::QUARTER_TURN) begin
            n_z0   = w_z_raw - usvg_pkg::HALF_TURN;
            n_neg0 = 1'b1;
        end else if (w_z_raw < -usvg_pkg::QUARTER_TURN) begin
            n_z0   = w_z_raw + usvg_pkg::HALF_TURN;
            n_neg0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z0   <= n_z0;
            r_neg0 <= n_neg0;
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_it
        if (s == 0) begin : g_head
            assign w_xi[s] = usvg_pkg::CORDIC_GAIN;
            assign w_yi[s] = '0;
            assign w_zi[s] = r_z0;
            assign w_ni[s] = r_neg0;
        end else begin : g_body
            assign w_xi[s] = r_x[s-1];
            assign w_yi[s] = r_y[s-1];
            assign w_zi[s] = r_z[s-1];
            assign w_ni[s] = r_neg[s-1];
        end

        always_comb begin
            logic signed [CW-1:0] x;
            logic signed [CW-1:0] y;
            logic signed [CW-1:0] nx;
            logic signed [ZW-1:0] z;
            x = w_xi[s];
            y = w_yi[s];
            z = w_zi[s];
            for (int k = 0; k < usvg_pkg::COR_STEPS; k++) begin
                if (z >= 0) begin
                    nx = x - (y >>> (s * usvg_pkg::COR_STEPS + k));
                    y  = y + (x >>> (s * usvg_pkg::COR_STEPS + k));
                    z  = z - usvg_pkg::ATAN_TURNS[s * usvg_pkg::COR_STEPS + k];
                end else begin
                    nx = x + (y >>> (s * usvg_pkg::COR_STEPS + k));
                    y  = y - (x >>> (s * usvg_pkg::COR_STEPS + k));
                    z  = z + usvg_pkg::ATAN_TURNS[s * usvg_pkg::COR_STEPS + k];
                end
                x = nx;
            end
            n_x[s] = x;
            n_y[s] = y;
            n_z[s] = z;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s]   <= n_x[s];
                r_y[s]   <= n_y[s];
                r_z[s]   <= n_z[s];
                r_neg[s] <= w_ni[s];
            end
        end
    end

    assign w_xf = r_neg[NS-1] ? -r_x[NS-1] : r_x[NS-1];
    assign w_yf = r_neg[NS-1] ? -r_y[NS-1] : r_y[NS-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin <= usvg_pkg::q30_to_q16(w_yf);
            o_cos <= usvg_pkg::q30_to_q16(w_xf);
        end
    end

endmodule

`default_nettype wire
